>>> sv/ehtc_pkg.sv
package ehtc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMaintGetType   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFormatInfoType = 2'd1;

  localparam int unsigned TypeW = 7;
  localparam logic [TypeW-1:0] MaintGetTypeRst   = 7'd2;
  localparam logic [TypeW-1:0] FormatInfoTypeRst = 7'd4;

  // shortest legal format info option length
  localparam logic [7:0] FormatMinLen = 8'd2;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_MAINT  = 2'd1,
    KIND_FORMAT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_OPTION = 2'd1,
    VERDICT_DROP   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    verdict_e    verdict;
    logic        maint_requested;
    logic        format_seen;
    logic [7:0]  format_first;
    logic [7:0]  format_second;
    logic [15:0] header_size;
  } out_t;

endpackage

>>> sv/ehtc_walker.sv
module ehtc_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  ehtc_pkg::in_t               item_i,
  input  logic [ehtc_pkg::TypeW-1:0]  maint_type_i,
  input  logic [ehtc_pkg::TypeW-1:0]  format_type_i,
  output ehtc_pkg::out_t              res_o
);
  import ehtc_pkg::*;

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  pos_q, pos_d;
  verdict_e    err_q, err_d;
  logic        maint_q, maint_d;
  logic        fmt_flag_q, fmt_flag_d;
  logic [7:0]  fmt0_q, fmt0_d;
  logic [7:0]  fmt1_q, fmt1_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  b;

  assign b = item_i.hdr_byte;

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    left_d     = left_q;
    pos_d      = pos_q;
    err_d      = err_q;
    maint_d    = maint_q;
    fmt_flag_d = fmt_flag_q;
    fmt0_d     = fmt0_q;
    fmt1_d     = fmt1_q;
    cnt_d      = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

    if (err_q == VERDICT_OK) begin
      unique case (phase_q)
        PH_TYPE: begin
          priority if (b[TypeW-1:0] == maint_type_i) begin
            kind_d  = KIND_MAINT;
            maint_d = 1'b1;
            phase_d = PH_LEN;
          end else if (b[TypeW-1:0] == format_type_i) begin
            kind_d  = KIND_FORMAT;
            phase_d = PH_LEN;
          end else if (b[7]) begin
            err_d = VERDICT_OPTION;
          end else begin
            kind_d  = KIND_OTHER;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (kind_q == KIND_FORMAT && b < FormatMinLen) begin
            err_d = VERDICT_OPTION;
          end else begin
            left_d  = b;
            pos_d   = 2'd0;
            phase_d = (b == 8'd0) ? PH_TYPE : PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (kind_q == KIND_FORMAT && !pos_q[1]) begin
            if (pos_q[0]) begin
              fmt1_d     = b;
              fmt_flag_d = 1'b1;
            end else begin
              fmt0_d = b;
            end
          end
          if (!pos_q[1]) pos_d = pos_q + 2'd1;
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = PH_TYPE;
        end
        default: phase_d = PH_TYPE;
      endcase
    end
  end

  always_comb begin
    res_o.verdict = err_d;
    if (err_d == VERDICT_OK && phase_d != PH_TYPE) res_o.verdict = VERDICT_DROP;
    res_o.maint_requested = maint_d;
    res_o.format_seen     = fmt_flag_d;
    res_o.format_first    = fmt0_d;
    res_o.format_second   = fmt1_d;
    res_o.header_size     = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      kind_q     <= KIND_OTHER;
      left_q     <= '0;
      pos_q      <= '0;
      err_q      <= VERDICT_OK;
      maint_q    <= 1'b0;
      fmt_flag_q <= 1'b0;
      fmt0_q     <= '0;
      fmt1_q     <= '0;
      cnt_q      <= '0;
    end else if (fire_i) begin
      if (item_i.final_byte) begin
        // header done, start the next one clean
        phase_q    <= PH_TYPE;
        kind_q     <= KIND_OTHER;
        left_q     <= '0;
        pos_q      <= '0;
        err_q      <= VERDICT_OK;
        maint_q    <= 1'b0;
        fmt_flag_q <= 1'b0;
        fmt0_q     <= '0;
        fmt1_q     <= '0;
        cnt_q      <= '0;
      end else begin
        phase_q    <= phase_d;
        kind_q     <= kind_d;
        left_q     <= left_d;
        pos_q      <= pos_d;
        err_q      <= err_d;
        maint_q    <= maint_d;
        fmt_flag_q <= fmt_flag_d;
        fmt0_q     <= fmt0_d;
        fmt1_q     <= fmt1_d;
        cnt_q      <= cnt_d;
      end
    end
  end

endmodule

>>> sv/ehtc_out_reg.sv
module ehtc_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ehtc_pkg::out_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ehtc_pkg::out_t out_data_o
);
  import ehtc_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i)           valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> sv/ext_header_tlv_checker.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i   (hdr_byte, final_byte)
// out     | output    | out_valid_o/out_ready_i | out_data_o  (verdict, flags, bytes, size)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one header byte per cycle sustained while the output slot can take each final
// byte; the option walk updates state as a byte leaves the input register, and
// the final byte's result is loaded into the output register as it leaves
// reset clears walk state, the input register valid and the output valid
// a stalled result only holds up the input register once a final byte waits
module ext_header_tlv_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ehtc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ehtc_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ehtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import ehtc_pkg::*;

  // option type codes; the user must write them only while idle, the block does not enforce it
  logic [TypeW-1:0] maint_type_q;
  logic [TypeW-1:0] format_type_q;

  // input register
  logic stg_valid_q, stg_valid_d;
  in_t  stg_q;

  logic stg_fire;
  logic res_free;
  out_t res;

  // a non-final byte never needs the output slot
  assign stg_fire   = stg_valid_q && (!stg_q.final_byte || res_free);
  assign in_ready_o = !stg_valid_q || stg_fire;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_valid_i && in_ready_o) stg_valid_d = 1'b1;
    else if (stg_fire)            stg_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stg_valid_q <= 1'b0;
    else         stg_valid_q <= stg_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) stg_q <= in_data_i;
  end

  // configuration transactions are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maint_type_q  <= MaintGetTypeRst;
      format_type_q <= FormatInfoTypeRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMaintGetType)   maint_type_q  <= cfg_data_i[TypeW-1:0];
      if (cfg_index_i == CfgFormatInfoType) format_type_q <= cfg_data_i[TypeW-1:0];
    end
  end

  ehtc_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (stg_fire),
    .item_i        (stg_q),
    .maint_type_i  (maint_type_q),
    .format_type_i (format_type_q),
    .res_o         (res)
  );

  // result slot, loaded only for the final byte of a header
  ehtc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stg_fire && stg_q.final_byte),
    .res_i       (res),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
